@@ hw/rtl/dual_quadrature_counter_speed_top_macros.svh @@
// Assertion macros shared by the encoder counter RTL.
`ifndef DUAL_QUADRATURE_COUNTER_SPEED_TOP_MACROS_SVH
`define DUAL_QUADRATURE_COUNTER_SPEED_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DQCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dqcs_pkg.sv @@
// Types, constants and helper functions of the dual encoder counter.
`default_nettype none

package dqcs_pkg;

  localparam int COUNT_WIDTH = 32;

  localparam int SCALE_W     = 10;
  localparam int KEEP_W      = 9;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_SCALE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_KEEP = 1'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd100;
  localparam logic [KEEP_W-1:0]  KEEP_RESET  = 9'd179;
  localparam logic [KEEP_W-1:0]  KEEP_FULL   = 9'd256;

  // Count delta is clamped to a 33-bit signed range before scaling.
  localparam int DELTA_W = 33;
  localparam int WIDE_W  = (COUNT_WIDTH > DELTA_W) ? COUNT_WIDTH : DELTA_W;
  localparam int PROD1_W = DELTA_W + SCALE_W + 1;
  localparam int WPROD_W = 32 + KEEP_W + 1;
  localparam int ACC_W   = WPROD_W + 1;

  localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};

  // Limits of delta * scale before the Q8 shift so that the result fits 32 bits.
  localparam logic signed [PROD1_W-1:0] FRESH_HI = PROD1_W'(24'sh7F_FFFF);
  localparam logic signed [PROD1_W-1:0] FRESH_LO = PROD1_W'(signed'(24'h80_0000));

  localparam logic signed [ACC_W-1:0] SPEED_HI   = ACC_W'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SPEED_LO   = ACC_W'(signed'(32'h8000_0000));
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(9'sd128);

  typedef struct packed {
    logic left_a;
    logic left_b;
    logic right_a;
    logic right_b;
    logic speed_tick;
  } dqcs_in_t;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic               speed_valid;
  } dqcs_out_t;

  // Per-cycle commands from the sequencer to each lane.
  typedef struct packed {
    logic accept;
    logic step1;
    logic step2;
    logic step3;
  } dqcs_ctrl_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [KEEP_W-1:0]  keep;
  } dqcs_cfg_t;

  typedef struct packed {
    logic signed [COUNT_WIDTH-1:0] count_next;
    logic signed [COUNT_WIDTH-1:0] count;
    logic signed [31:0]            speed;
  } dqcs_lane_t;

  function automatic logic signed [DELTA_W-1:0] clamp_delta(
    input logic signed [COUNT_WIDTH-1:0] d
  );
    logic signed [WIDE_W-1:0] w;
    w = WIDE_W'(d);
    if (w > WIDE_W'(DELTA_MAX)) begin
      return DELTA_MAX;
    end
    if (w < WIDE_W'(DELTA_MIN)) begin
      return DELTA_MIN;
    end
    return DELTA_W'(w);
  endfunction

  function automatic logic signed [31:0] to_count32(
    input logic signed [COUNT_WIDTH-1:0] c
  );
    return 32'(c);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dqcs_lane.sv @@
// One encoder lane: x1 edge counter and the three-step speed lowpass.
`default_nettype none

module dqcs_lane import dqcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dqcs_ctrl_t ctrl,
  input  dqcs_cfg_t  cfg,
  input  logic       mirror,
  input  logic       a,
  input  logic       b,
  output dqcs_lane_t stat
);

  logic signed [COUNT_WIDTH-1:0] count;
  logic signed [COUNT_WIDTH-1:0] count_next;
  logic signed [COUNT_WIDTH-1:0] last_count;
  logic signed [31:0]            speed;
  logic                          prev_a;

  logic signed [DELTA_W-1:0]     delta;
  logic signed [SCALE_W:0]       scale_s;
  logic signed [PROD1_W-1:0]     prod1;
  logic signed [31:0]            fresh;
  logic signed [KEEP_W:0]        keep_s;
  logic signed [KEEP_W:0]        gain_s;
  logic signed [WPROD_W-1:0]     prod_old;
  logic signed [WPROD_W-1:0]     prod_new;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       acc_shift;
  logic signed [31:0]            speed_next;
  logic                          rise;
  logic                          up;

  // The left lane counts up while B is low, the right lane while B is high.
  always_comb begin
    rise = a && !prev_a;
    up   = mirror ? b : !b;
    count_next = count;
    if (rise) begin
      count_next = up ? count + COUNT_WIDTH'(1) : count - COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    delta   = clamp_delta(count - last_count);
    scale_s = signed'({1'b0, cfg.scale});
    keep_s  = signed'({1'b0, cfg.keep});
    gain_s  = signed'({1'b0, KEEP_FULL - cfg.keep});

    if (prod1 > FRESH_HI) begin
      fresh = 32'sh7FFF_FFFF;
    end else if (prod1 < FRESH_LO) begin
      fresh = signed'(32'h8000_0000);
    end else begin
      fresh = signed'({prod1[23:0], 8'h00});
    end

    // Arithmetic shift floors, so the half bias rounds ties upward.
    acc       = ACC_W'(prod_old) + ACC_W'(prod_new) + ROUND_HALF;
    acc_shift = acc >>> 8;
    if (acc_shift > SPEED_HI) begin
      speed_next = 32'sh7FFF_FFFF;
    end else if (acc_shift < SPEED_LO) begin
      speed_next = signed'(32'h8000_0000);
    end else begin
      speed_next = 32'(acc_shift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      last_count <= '0;
      speed      <= '0;
      prev_a     <= 1'b1;
    end else begin
      if (ctrl.accept) begin
        count  <= count_next;
        prev_a <= a;
      end
      if (ctrl.step1) begin
        last_count <= count;
      end
      if (ctrl.step3) begin
        speed <= speed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step1) begin
      prod1 <= delta * scale_s;
    end
    if (ctrl.step2) begin
      prod_old <= keep_s * speed;
      prod_new <= gain_s * fresh;
    end
  end

  assign stat.count_next = count_next;
  assign stat.count      = count;
  assign stat.speed      = speed;

endmodule

`default_nettype wire

@@ hw/rtl/dual_quadrature_counter_speed_top.sv @@
// Top level of the dual quadrature encoder counter with filtered speed.
`default_nettype none
`include "dual_quadrature_counter_speed_top_macros.svh"

// Two x1 quadrature counters, one lane per encoder, with a lowpass speed
// estimate updated on each speed tick. Every accepted beat gives exactly one
// result beat. A beat without a tick goes straight to the output register,
// so such beats can be accepted back to back while the output register drains.
// A beat with a tick counts its edges, then runs the speed arithmetic
// (delta times scale, the two weighted Q8 products, then round and saturate)
// in both lanes at once, then loads the output register. The counts wrap;
// speeds are Q24.8 and saturate to 32 bits. A filter_keep above 256 acts as
// 256. Configuration writes take effect at once.
module dual_quadrature_counter_speed_top import dqcs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  dqcs_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output dqcs_out_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_S1   = 3'd1;
  localparam logic [2:0] ST_S2   = 3'd2;
  localparam logic [2:0] ST_S3   = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [SCALE_W-1:0] speed_scale;
  logic [KEEP_W-1:0]  filter_keep;
  dqcs_cfg_t          cfg;
  dqcs_ctrl_t         ctrl;
  dqcs_lane_t         left_stat;
  dqcs_lane_t         right_stat;
  logic               out_free;
  logic               accept;
  logic               load_direct;
  logic               load_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale <= SCALE_RESET;
      filter_keep <= KEEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPEED_SCALE: speed_scale <= cfg_data[SCALE_W-1:0];
        REG_FILTER_KEEP: filter_keep <= cfg_data[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.scale = speed_scale;
  assign cfg.keep  = (filter_keep > KEEP_FULL) ? KEEP_FULL : filter_keep;

  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != ST_IDLE) || !out_free;
  assign accept      = in_valid && !in_stall;
  assign load_direct = accept && !in_data.speed_tick;
  assign load_emit   = (state == ST_EMIT) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && in_data.speed_tick) state_next = ST_S1;
      ST_S1:   state_next = ST_S2;
      ST_S2:   state_next = ST_S3;
      ST_S3:   state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ctrl.accept = accept;
  assign ctrl.step1  = (state == ST_S1);
  assign ctrl.step2  = (state == ST_S2);
  assign ctrl.step3  = (state == ST_S3);

  dqcs_lane u_left (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .mirror (1'b0),
    .a      (in_data.left_a),
    .b      (in_data.left_b),
    .stat   (left_stat)
  );

  dqcs_lane u_right (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .mirror (1'b1),
    .a      (in_data.right_a),
    .b      (in_data.right_b),
    .stat   (right_stat)
  );

  // Merge both lanes into the output register. A beat without a tick
  // is written straight from the lanes' next counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_direct || load_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      out_data.left_count  <= to_count32(left_stat.count_next);
      out_data.right_count <= to_count32(right_stat.count_next);
      out_data.left_speed  <= left_stat.speed;
      out_data.right_speed <= right_stat.speed;
      out_data.speed_valid <= 1'b0;
    end else if (load_emit) begin
      out_data.left_count  <= to_count32(left_stat.count);
      out_data.right_count <= to_count32(right_stat.count);
      out_data.left_speed  <= left_stat.speed;
      out_data.right_speed <= right_stat.speed;
      out_data.speed_valid <= 1'b1;
    end
  end

  `DQCS_ASSERT_NEXT(a_plain_beat_out, in_valid && !in_stall && !in_data.speed_tick, out_valid && !out_data.speed_valid, "beat without tick did not reach the output")
  `DQCS_ASSERT_SAME(a_no_overwrite, in_valid && !in_stall, !(out_valid && out_stall), "beat accepted while a stalled result waits")
  `DQCS_ASSERT_SAME(a_emit_order, state == ST_EMIT, ($past(state) == ST_S3) || ($past(state) == ST_EMIT), "speed result emitted out of sequence")

endmodule

`default_nettype wire

@@ tb/sv/dual_quadrature_counter_speed_top_tb.sv @@
// Self-checking testbench for the dual quadrature encoder counter with filtered speed.
`timescale 1ns / 1ps

module dual_quadrature_counter_speed_top_tb;
  import dqcs_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int BURST_EDGES   = 60;
  localparam int PHASE_BEATS   = 125;
  localparam int N_PHASES      = 6;
  localparam int N_SCRIPT      = 15;
  localparam int IDLE_PCT      = 22;
  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;

  typedef struct {
    dqcs_in_t  item;
    bit        has_exp;
    dqcs_out_t exp;
  } enc_beat_t;

  typedef struct packed {
    logic [4:0]         pins;   // left_a, left_b, right_a, right_b, speed_tick
    logic               typed;
    logic signed [31:0] lc;
    logic signed [31:0] rc;
    logic signed [31:0] ls;
    logic signed [31:0] rs;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  dqcs_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  dqcs_out_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_SPEED_SCALE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  dual_quadrature_counter_speed_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Encoder state as the block should hold it.
  logic [31:0]        pos_cnt [2];
  logic [31:0]        pos_at_tick [2];
  logic signed [31:0] spd [2];
  logic               a_prev [2];
  logic [SCALE_W-1:0] cur_scale;
  logic [KEEP_W-1:0]  cur_keep;

  enc_beat_t pending_beats [$];
  dqcs_out_t awaited_results [$];

  bit calm = 1'b0;
  int cycles = 0;
  int mismatches = 0;
  int beats_in = 0;
  int ticks_in = 0;
  int results_out = 0;
  int saturated_speeds = 0;

  // Stimulus generator state: quadrature phase and heading per side.
  int quad_ph [2];
  int heading [2];

  script_row_t script [0:N_SCRIPT-1] = '{
    '{5'b11111, 1'b1, 32'sd0, 32'sd0,  32'sd0,    32'sd0},
    '{5'b00000, 1'b1, 32'sd0, 32'sd0,  32'sd0,    32'sd0},
    '{5'b10100, 1'b1, 32'sd1, -32'sd1, 32'sd0,    32'sd0},
    '{5'b00000, 1'b0, 32'sd0, 32'sd0,  32'sd0,    32'sd0},
    '{5'b11110, 1'b1, 32'sd0, 32'sd0,  32'sd0,    32'sd0},
    '{5'b00000, 1'b0, 32'sd0, 32'sd0,  32'sd0,    32'sd0},
    '{5'b10101, 1'b1, 32'sd1, -32'sd1, 32'sd7700, -32'sd7700},
    '{5'b11110, 1'b0, 32'sd0, 32'sd0,  32'sd0,    32'sd0},
    '{5'b01010, 1'b0, 32'sd0, 32'sd0,  32'sd0,    32'sd0},
    '{5'b00001, 1'b0, 32'sd0, 32'sd0,  32'sd0,    32'sd0},
    '{5'b10000, 1'b0, 32'sd0, 32'sd0,  32'sd0,    32'sd0},
    '{5'b00111, 1'b0, 32'sd0, 32'sd0,  32'sd0,    32'sd0},
    '{5'b00000, 1'b0, 32'sd0, 32'sd0,  32'sd0,    32'sd0},
    '{5'b11111, 1'b0, 32'sd0, 32'sd0,  32'sd0,    32'sd0},
    '{5'b00001, 1'b0, 32'sd0, 32'sd0,  32'sd0,    32'sd0}
  };

  logic [CFG_DATA_W-1:0] scale_set [N_PHASES] = '{10'd1000, 10'd1, 10'd0, 10'd1023,
                                                  10'd537, 10'd100};
  logic [CFG_DATA_W-1:0] keep_set [N_PHASES]  = '{10'd0, 10'd256, 10'd128, 10'd300,
                                                  10'h3FF, 10'd179};

  function automatic logic signed [31:0] clip32(longint v);
    if (v > S32_MAX) return 32'sh7FFF_FFFF;
    if (v < S32_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void count_edge(int side, logic a, logic b);
    if (a && !a_prev[side]) begin
      if ((side == 0) ? !b : b) pos_cnt[side] = pos_cnt[side] + 32'd1;
      else pos_cnt[side] = pos_cnt[side] - 32'd1;
    end
    a_prev[side] = a;
  endfunction

  // Q8 lowpass of count delta times scale; the shift on a signed sum floors.
  function automatic void refresh_speed(int side);
    logic signed [31:0] delta;
    longint fresh;
    longint k;
    longint acc;
    delta = pos_cnt[side] - pos_at_tick[side];
    fresh = clip32(longint'(delta) * longint'(cur_scale) * 64'sd256);
    if (cur_keep > KEEP_FULL) k = 256;
    else k = longint'(cur_keep);
    acc = k * longint'(spd[side]) + (64'sd256 - k) * fresh + 64'sd128;
    spd[side] = clip32(acc >>> 8);
    pos_at_tick[side] = pos_cnt[side];
  endfunction

  function automatic dqcs_out_t advance_encoders(dqcs_in_t it);
    dqcs_out_t r;
    count_edge(0, it.left_a, it.left_b);
    count_edge(1, it.right_a, it.right_b);
    if (it.speed_tick) begin
      refresh_speed(0);
      refresh_speed(1);
    end
    r.left_count  = pos_cnt[0];
    r.right_count = pos_cnt[1];
    r.left_speed  = spd[0];
    r.right_speed = spd[1];
    r.speed_valid = it.speed_tick;
    return r;
  endfunction

  function automatic logic [1:0] gray_pins(int ph);
    case (ph & 3)
      0: return 2'b00;
      1: return 2'b10;
      2: return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  // Mostly clean quadrature motion per side, with a share of random pin noise.
  function automatic dqcs_in_t random_pins();
    dqcs_in_t it;
    logic [1:0] lp;
    logic [1:0] rp;
    if ($urandom_range(99) < 25) begin
      it = dqcs_in_t'(5'($urandom_range(31)));
      quad_ph[0] = it.left_a ? (it.left_b ? 2 : 1) : (it.left_b ? 3 : 0);
      quad_ph[1] = it.right_a ? (it.right_b ? 2 : 1) : (it.right_b ? 3 : 0);
    end else begin
      for (int s = 0; s < 2; s++) begin
        if ($urandom_range(19) == 0) heading[s] = int'($urandom_range(2)) - 1;
        if ($urandom_range(9) < 6) quad_ph[s] = (quad_ph[s] + heading[s]) & 3;
      end
      lp = gray_pins(quad_ph[0]);
      rp = gray_pins(quad_ph[1]);
      it = {lp, rp, ($urandom_range(9) == 0)};
    end
    return it;
  endfunction

  task automatic queue_beat(dqcs_in_t it);
    enc_beat_t b;
    b.item = it;
    b.has_exp = 1'b0;
    b.exp = '0;
    pending_beats.push_back(b);
  endtask

  task automatic settle();
    while (pending_beats.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] scale, logic [CFG_DATA_W-1:0] keep);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_SPEED_SCALE;
    cfg_data <= scale;
    cur_scale = scale[SCALE_W-1:0];
    @(posedge clk);
    cfg_index <= REG_FILTER_KEEP;
    cfg_data <= keep;
    cur_keep = keep[KEEP_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input side: offer queued beats, predict each one as it is taken.
  always @(posedge clk) begin : feed
    enc_beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        b = pending_beats.pop_front();
        awaited_results.push_back(b.has_exp ? b.exp : advance_encoders(b.item));
        if (b.has_exp) void'(advance_encoders(b.item));
        beats_in++;
        if (b.item.speed_tick) ticks_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data <= pending_beats[0].item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: random stalls and the comparison against the oldest expectation.
  always @(posedge clk) begin : sink
    dqcs_out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_out++;
      if (out_data.left_speed == 32'sh7FFF_FFFF || out_data.left_speed == 32'sh8000_0000 ||
          out_data.right_speed == 32'sh7FFF_FFFF || out_data.right_speed == 32'sh8000_0000)
        saturated_speeds++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat %0d arrived with nothing expected", results_out);
      end else begin
        want = awaited_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result beat %0d: expected lc=%0d rc=%0d ls=%0d rs=%0d v=%0b",
                     results_out, want.left_count, want.right_count, want.left_speed,
                     want.right_speed, want.speed_valid);
            $display("  got lc=%0d rc=%0d ls=%0d rs=%0d v=%0b", out_data.left_count,
                     out_data.right_count, out_data.left_speed, out_data.right_speed,
                     out_data.speed_valid);
          end
        end
      end
    end
    out_stall <= rst ? 1'b0 : (!calm && $urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               awaited_results.size());
      $display("dual_quadrature_counter_speed_top regression: fail");
      $finish;
    end
  end

  initial begin : main
    enc_beat_t b;
    for (int s = 0; s < 2; s++) begin
      pos_cnt[s] = '0;
      pos_at_tick[s] = '0;
      spd[s] = '0;
      a_prev[s] = 1'b1;
      quad_ph[s] = 0;
      heading[s] = 1;
    end
    cur_scale = SCALE_RESET;
    cur_keep = KEEP_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Short script under the reset settings: no false edge at start, both
    // directions on each side, ticks with and without edges in the same beat.
    for (int i = 0; i < N_SCRIPT; i++) begin
      b.item = dqcs_in_t'(script[i].pins);
      b.has_exp = script[i].typed;
      b.exp = '{script[i].lc, script[i].rc, script[i].ls, script[i].rs, script[i].pins[0]};
      pending_beats.push_back(b);
    end
    settle();

    // A one-way run between two ticks, with the new value taken at full weight,
    // moves the left speed up and the right speed down. This stretch runs
    // without idling.
    program_regs(scale_set[0], keep_set[0]);
    calm = 1'b1;
    for (int i = 0; i < BURST_EDGES; i++) begin
      queue_beat(dqcs_in_t'(5'b00000));
      queue_beat(dqcs_in_t'(5'b10100));
    end
    queue_beat(dqcs_in_t'(5'b00001));
    settle();
    calm = 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      program_regs(scale_set[p], keep_set[p]);
      for (int i = 0; i < PHASE_BEATS; i++) queue_beat(random_pins());
      settle();
    end

    $display("covered %0d input beats with %0d speed ticks over %0d register settings",
             beats_in, ticks_in, N_PHASES + 1);
    $display("%0d results checked, %0d with a saturated speed, %0d mismatches",
             results_out, saturated_speeds, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("dual_quadrature_counter_speed_top regression: pass");
    end else begin
      $display("dual_quadrature_counter_speed_top regression: fail");
    end
    $finish;
  end

endmodule
